FILE: sv/rra_pkg.sv
package rra_pkg;

  localparam int MaxRounds = 10;
  localparam int NumKeys = MaxRounds + 1;

  typedef logic [127:0] block_t;
  typedef logic [3:0] rnd_t;
  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_KEY_LOW = 2'd0;
  localparam cfg_idx_t CFG_KEY_HIGH = 2'd1;
  localparam cfg_idx_t CFG_ROUND_COUNT = 2'd2;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef enum logic [1:0] {
    KS_IDLE,
    KS_LOAD,
    KS_EXPAND,
    KS_REVERSE
  } ks_state_t;

  typedef enum logic [1:0] {
    RND_PASS,
    RND_FULL,
    RND_LAST
  } rnd_kind_t;

  typedef struct packed {
    logic valid;
    logic op;
    block_t data;
  } stage_t;

  typedef struct packed {
    logic en;
    rnd_kind_t kind;
  } rnd_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) acc = acc ^ x;
      x = xtime(x);
    end
    gmul = acc;
  endfunction

  function automatic block_t sub_shift(input block_t s);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(r+4*c) +: 8] = SBOX[s[8*(r+4*((c+r)%4)) +: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic block_t inv_sub_shift(input block_t s);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(r+4*((c+r)%4)) +: 8] = INV_SBOX[s[8*(r+4*c) +: 8]];
      end
    end
    inv_sub_shift = t;
  endfunction

  function automatic block_t mix_cols(input block_t s, input logic inv);
    block_t t;
    logic [3:0] m [4];
    logic [7:0] acc;
    if (inv) begin
      m = '{4'he, 4'hb, 4'hd, 4'h9};
    end else begin
      m = '{4'h2, 4'h3, 4'h1, 4'h1};
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) begin
          acc = acc ^ gmul(s[8*(4*c+k) +: 8], m[(4+k-r)%4]);
        end
        t[8*(4*c+r) +: 8] = acc;
      end
    end
    mix_cols = t;
  endfunction

  function automatic block_t expand_step(input block_t k, input logic [7:0] rc);
    logic [31:0] t;
    logic [31:0] w [4];
    t = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]], SBOX[k[111:104]] ^ rc};
    w[0] = k[31:0] ^ t;
    w[1] = k[63:32] ^ w[0];
    w[2] = k[95:64] ^ w[1];
    w[3] = k[127:96] ^ w[2];
    expand_step = {w[3], w[2], w[1], w[0]};
  endfunction

endpackage

FILE: sv/rra_if.sv
interface rra_in_if;
  logic valid;
  logic ready;
  logic op;
  logic [63:0] block_low;
  logic [63:0] block_high;
  modport source(output valid, op, block_low, block_high, input ready);
  modport sink(input valid, op, block_low, block_high, output ready);
endinterface

interface rra_out_if;
  logic valid;
  logic ready;
  logic [63:0] result_low;
  logic [63:0] result_high;
  modport source(output valid, result_low, result_high, input ready);
  modport sink(input valid, result_low, result_high, output ready);
endinterface

interface rra_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [63:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: sv/rra_round.sv
module rra_round (
  input  logic              clk,
  input  logic              rst,
  input  rra_pkg::rnd_ctl_t ctl,
  input  rra_pkg::block_t   key_enc,
  input  rra_pkg::block_t   key_dec,
  input  rra_pkg::stage_t   din,
  output rra_pkg::stage_t   dout
);

  rra_pkg::block_t enc;
  rra_pkg::block_t dec;
  rra_pkg::block_t res;

  always_comb begin
    enc = rra_pkg::sub_shift(din.data);
    if (ctl.kind == rra_pkg::RND_FULL) enc = rra_pkg::mix_cols(enc, 1'b0);
    enc = enc ^ key_enc;
    dec = rra_pkg::inv_sub_shift(din.data) ^ key_dec;
    if (ctl.kind == rra_pkg::RND_FULL) dec = rra_pkg::mix_cols(dec, 1'b1);
    if (ctl.kind == rra_pkg::RND_PASS) begin
      res = din.data;
    end else if (din.op == rra_pkg::OP_ENCRYPT) begin
      res = enc;
    end else begin
      res = dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (ctl.en) begin
      dout.valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      dout.op <= din.op;
      dout.data <= res;
    end
  end

endmodule

FILE: sv/reduced_round_aes128_crypt.sv
// AES-128 with 1 to 10 rounds, encrypt or decrypt per item. Fully unrolled: one item per
// cycle while the key schedule is idle and the output is not stalled; one key-add stage
// plus one stage per round (unused rounds pass the block through). A key register write
// starts the key schedule, which runs one round key per cycle and then lays out the
// decryption keys, with no input accepted meanwhile. A round_count write redoes only the layout;
// reset runs the whole schedule. Configuration is accepted only while the schedule is idle.
module reduced_round_aes128_crypt (
  input logic      clk,
  input logic      rst,
  rra_in_if.sink   blk_in,
  rra_out_if.source blk_out,
  rra_cfg_if.sink  cfg
);

  rra_pkg::ks_state_t state;
  rra_pkg::ks_state_t state_next;
  logic [63:0] key_low;
  logic [63:0] key_high;
  rra_pkg::rnd_t rounds;
  rra_pkg::rnd_t cnt;
  rra_pkg::rnd_t cnt_next;
  rra_pkg::rnd_t rsel;
  logic [7:0] rcon;
  rra_pkg::block_t cur;
  rra_pkg::block_t rk [rra_pkg::NumKeys];
  rra_pkg::block_t dk [rra_pkg::NumKeys];
  rra_pkg::stage_t st [rra_pkg::NumKeys];
  rra_pkg::stage_t s0;
  logic en;
  logic cfg_wr;

  assign cfg.ready = (state == rra_pkg::KS_IDLE);
  assign cfg_wr = cfg.valid && cfg.ready;
  assign en = !st[rra_pkg::MaxRounds].valid || blk_out.ready;
  assign blk_in.ready = (state == rra_pkg::KS_IDLE) && en;
  assign blk_out.valid = st[rra_pkg::MaxRounds].valid;
  assign blk_out.result_low = st[rra_pkg::MaxRounds].data[63:0];
  assign blk_out.result_high = st[rra_pkg::MaxRounds].data[127:64];
  assign rsel = rounds - cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rra_pkg::KS_LOAD;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    unique case (state)
      rra_pkg::KS_IDLE: begin
        if (cfg_wr && (cfg.index == rra_pkg::CFG_KEY_LOW || cfg.index == rra_pkg::CFG_KEY_HIGH)) begin
          state_next = rra_pkg::KS_LOAD;
        end else if (cfg_wr && cfg.index == rra_pkg::CFG_ROUND_COUNT) begin
          state_next = rra_pkg::KS_REVERSE;
          cnt_next = '0;
        end
      end
      rra_pkg::KS_LOAD: begin
        state_next = rra_pkg::KS_EXPAND;
        cnt_next = 4'd1;
      end
      rra_pkg::KS_EXPAND: begin
        if (cnt == 4'(rra_pkg::MaxRounds)) begin
          state_next = rra_pkg::KS_REVERSE;
          cnt_next = '0;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      rra_pkg::KS_REVERSE: begin
        if (cnt == 4'(rra_pkg::MaxRounds)) begin
          state_next = rra_pkg::KS_IDLE;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      default: begin
        state_next = rra_pkg::KS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low <= '0;
      key_high <= '0;
      rounds <= 4'(rra_pkg::MaxRounds);
    end else if (cfg_wr) begin
      if (cfg.index == rra_pkg::CFG_KEY_LOW) key_low <= cfg.data;
      if (cfg.index == rra_pkg::CFG_KEY_HIGH) key_high <= cfg.data;
      if (cfg.index == rra_pkg::CFG_ROUND_COUNT) begin
        if (cfg.data[3:0] == 4'd0) begin
          rounds <= 4'd1;
        end else if (cfg.data[3:0] > 4'(rra_pkg::MaxRounds)) begin
          rounds <= 4'(rra_pkg::MaxRounds);
        end else begin
          rounds <= cfg.data[3:0];
        end
      end
    end
  end

  // key schedule and decryption key layout
  always_ff @(posedge clk) begin
    if (state == rra_pkg::KS_LOAD) begin
      cur <= {key_high, key_low};
      rk[0] <= {key_high, key_low};
      rcon <= 8'h01;
    end else if (state == rra_pkg::KS_EXPAND) begin
      cur <= rra_pkg::expand_step(cur, rcon);
      rk[cnt] <= rra_pkg::expand_step(cur, rcon);
      rcon <= rra_pkg::xtime(rcon);
    end else if (state == rra_pkg::KS_REVERSE && cnt <= rounds) begin
      dk[cnt] <= rk[rsel];
    end
  end

  always_comb begin
    s0.valid = blk_in.valid && blk_in.ready;
    s0.op = blk_in.op;
    if (blk_in.op == rra_pkg::OP_ENCRYPT) begin
      s0.data = {blk_in.block_high, blk_in.block_low} ^ rk[0];
    end else begin
      s0.data = {blk_in.block_high, blk_in.block_low} ^ dk[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else if (en) begin
      st[0].valid <= s0.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].op <= s0.op;
      st[0].data <= s0.data;
    end
  end

  for (genvar j = 1; j < rra_pkg::NumKeys; j++) begin : g_rnd
    rra_pkg::rnd_ctl_t ctl;
    always_comb begin
      ctl.en = en;
      if (4'(j) < rounds) begin
        ctl.kind = rra_pkg::RND_FULL;
      end else if (4'(j) == rounds) begin
        ctl.kind = rra_pkg::RND_LAST;
      end else begin
        ctl.kind = rra_pkg::RND_PASS;
      end
    end
    rra_round u_rnd (
      .clk(clk),
      .rst(rst),
      .ctl(ctl),
      .key_enc(rk[j]),
      .key_dec(dk[j]),
      .din(st[j-1]),
      .dout(st[j])
    );
  end

endmodule
